// File: rtl/core/abe_pkg.sv
`timescale 1ns / 1ps

package abe_pkg;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h20;

    typedef enum logic [5:0] {
        FN_ADC = 6'd0,  FN_SBC = 6'd1,  FN_AND = 6'd2,  FN_ORA = 6'd3,
        FN_EOR = 6'd4,  FN_ASL = 6'd5,  FN_LSR = 6'd6,  FN_ROL = 6'd7,
        FN_ROR = 6'd8,  FN_CMP = 6'd9,  FN_CPX = 6'd10, FN_CPY = 6'd11,
        FN_INC = 6'd12, FN_DEC = 6'd13, FN_BIT = 6'd14, FN_LDA = 6'd15,
        FN_LDX = 6'd16, FN_LDY = 6'd17, FN_INX = 6'd18, FN_INY = 6'd19,
        FN_DEX = 6'd20, FN_DEY = 6'd21, FN_TAX = 6'd22, FN_TAY = 6'd23,
        FN_TXA = 6'd24, FN_TYA = 6'd25, FN_TSX = 6'd26, FN_TXS = 6'd27,
        FN_CLC = 6'd28, FN_SEC = 6'd29, FN_CLD = 6'd30, FN_SED = 6'd31,
        FN_CLI = 6'd32, FN_SEI = 6'd33, FN_CLV = 6'd34, FN_STA = 6'd35,
        FN_STX = 6'd36, FN_STY = 6'd37
    } func_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
    } arch_t;

    typedef struct packed {
        logic [7:0] mem_data;
        logic       mem_write;
    } mem_req_t;

endpackage

// File: rtl/core/abe_bcd.sv
`timescale 1ns / 1ps

module abe_bcd (
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic       cin,
    input  logic       subtract,
    output logic [7:0] result,
    output logic       carry
);

    logic [9:0] add_raw;
    logic [9:0] add_lo;
    logic       add_lo_fix;
    logic [9:0] add_fin;
    logic [9:0] sub_raw;
    logic [9:0] sub_lo;
    logic       sub_lo_fix;
    logic [9:0] sub_fin;

    assign add_raw    = {2'b00, a} + {2'b00, b} + {9'd0, cin};
    assign add_lo_fix = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin}) > 5'd9;
    assign add_lo     = add_lo_fix ? add_raw + 10'h006 : add_raw;
    assign add_fin    = (add_lo > 10'h099) ? add_lo + 10'h060 : add_lo;

    assign sub_raw    = {2'b00, a} - {2'b00, b} - {9'd0, ~cin};
    assign sub_lo_fix = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, ~cin});
    assign sub_lo     = sub_lo_fix ? sub_raw - 10'h006 : sub_raw;
    assign sub_fin    = sub_lo[9] ? sub_lo - 10'h060 : sub_lo;

    assign result = subtract ? sub_fin[7:0] : add_fin[7:0];
    assign carry  = add_fin > 10'h099;

endmodule

// File: rtl/core/abe_exec.sv
`timescale 1ns / 1ps

module abe_exec (
    input  logic [5:0]        func,
    input  logic [7:0]        operand,
    input  logic              on_accumulator,
    input  abe_pkg::arch_t    cur,
    output abe_pkg::arch_t    nxt,
    output abe_pkg::mem_req_t mem
);

    import abe_pkg::*;

    logic       cin;
    logic       is_sub;
    logic [7:0] addend;
    logic [8:0] bin_sum;
    logic       bin_ovf;
    logic [7:0] bcd_result;
    logic       bcd_carry;
    logic [7:0] src;
    logic [7:0] shl;
    logic [7:0] shr;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] shift_val;
    logic [7:0] zn_val;
    logic       zn_en;

    assign cin     = cur.flags[FL_C];
    assign is_sub  = func_t'(func) == FN_SBC;
    assign addend  = is_sub ? ~operand : operand;
    assign bin_sum = {1'b0, cur.acc} + {1'b0, addend} + {8'd0, cin};
    assign bin_ovf = (~(cur.acc[7] ^ addend[7])) & (cur.acc[7] ^ bin_sum[7]);

    abe_bcd u_bcd (
        .a        (cur.acc),
        .b        (operand),
        .cin      (cin),
        .subtract (is_sub),
        .result   (bcd_result),
        .carry    (bcd_carry)
    );

    assign src = on_accumulator ? cur.acc : operand;
    assign shl = {src[6:0], (func_t'(func) == FN_ROL) ? cin : 1'b0};
    assign shr = {(func_t'(func) == FN_ROR) ? cin : 1'b0, src[7:1]};

    always_comb begin
        case (func_t'(func))
            FN_CPX:  cmp_reg = cur.x;
            FN_CPY:  cmp_reg = cur.y;
            default: cmp_reg = cur.acc;
        endcase
    end

    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    always_comb begin
        nxt       = cur;
        mem       = '0;
        zn_en     = 1'b1;
        zn_val    = 8'd0;
        shift_val = 8'd0;
        case (func_t'(func))
            FN_ADC, FN_SBC: begin
                nxt.flags[FL_V] = bin_ovf;
                if (cur.flags[FL_D]) begin
                    nxt.acc         = bcd_result;
                    nxt.flags[FL_C] = is_sub ? bin_sum[8] : bcd_carry;
                end else begin
                    nxt.acc         = bin_sum[7:0];
                    nxt.flags[FL_C] = bin_sum[8];
                end
                zn_val = nxt.acc;
            end
            FN_AND: begin
                nxt.acc = cur.acc & operand;
                zn_val  = nxt.acc;
            end
            FN_ORA: begin
                nxt.acc = cur.acc | operand;
                zn_val  = nxt.acc;
            end
            FN_EOR: begin
                nxt.acc = cur.acc ^ operand;
                zn_val  = nxt.acc;
            end
            FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
                if (func_t'(func) == FN_ASL || func_t'(func) == FN_ROL) begin
                    shift_val       = shl;
                    nxt.flags[FL_C] = src[7];
                end else begin
                    shift_val       = shr;
                    nxt.flags[FL_C] = src[0];
                end
                zn_val = shift_val;
                if (on_accumulator) begin
                    nxt.acc = shift_val;
                end else begin
                    mem.mem_data  = shift_val;
                    mem.mem_write = 1'b1;
                end
            end
            FN_CMP, FN_CPX, FN_CPY: begin
                nxt.flags[FL_C] = ~cmp_diff[8];
                zn_val          = cmp_diff[7:0];
            end
            FN_INC: begin
                mem.mem_data  = operand + 8'd1;
                mem.mem_write = 1'b1;
                zn_val        = mem.mem_data;
            end
            FN_DEC: begin
                mem.mem_data  = operand - 8'd1;
                mem.mem_write = 1'b1;
                zn_val        = mem.mem_data;
            end
            FN_BIT: begin
                zn_en           = 1'b0;
                nxt.flags[FL_Z] = (cur.acc & operand) == 8'd0;
                nxt.flags[FL_N] = operand[7];
                nxt.flags[FL_V] = operand[6];
            end
            FN_LDA: begin
                nxt.acc = operand;
                zn_val  = operand;
            end
            FN_LDX: begin
                nxt.x  = operand;
                zn_val = operand;
            end
            FN_LDY: begin
                nxt.y  = operand;
                zn_val = operand;
            end
            FN_INX: begin
                nxt.x  = cur.x + 8'd1;
                zn_val = nxt.x;
            end
            FN_INY: begin
                nxt.y  = cur.y + 8'd1;
                zn_val = nxt.y;
            end
            FN_DEX: begin
                nxt.x  = cur.x - 8'd1;
                zn_val = nxt.x;
            end
            FN_DEY: begin
                nxt.y  = cur.y - 8'd1;
                zn_val = nxt.y;
            end
            FN_TAX: begin
                nxt.x  = cur.acc;
                zn_val = cur.acc;
            end
            FN_TAY: begin
                nxt.y  = cur.acc;
                zn_val = cur.acc;
            end
            FN_TXA: begin
                nxt.acc = cur.x;
                zn_val  = cur.x;
            end
            FN_TYA: begin
                nxt.acc = cur.y;
                zn_val  = cur.y;
            end
            FN_TSX: begin
                nxt.x  = cur.sp;
                zn_val = cur.sp;
            end
            FN_TXS: begin
                zn_en  = 1'b0;
                nxt.sp = cur.x;
            end
            FN_CLC: begin
                zn_en           = 1'b0;
                nxt.flags[FL_C] = 1'b0;
            end
            FN_SEC: begin
                zn_en           = 1'b0;
                nxt.flags[FL_C] = 1'b1;
            end
            FN_CLD: begin
                zn_en           = 1'b0;
                nxt.flags[FL_D] = 1'b0;
            end
            FN_SED: begin
                zn_en           = 1'b0;
                nxt.flags[FL_D] = 1'b1;
            end
            FN_CLI: begin
                zn_en           = 1'b0;
                nxt.flags[FL_I] = 1'b0;
            end
            FN_SEI: begin
                zn_en           = 1'b0;
                nxt.flags[FL_I] = 1'b1;
            end
            FN_CLV: begin
                zn_en           = 1'b0;
                nxt.flags[FL_V] = 1'b0;
            end
            FN_STA: begin
                zn_en         = 1'b0;
                mem.mem_data  = cur.acc;
                mem.mem_write = 1'b1;
            end
            FN_STX: begin
                zn_en         = 1'b0;
                mem.mem_data  = cur.x;
                mem.mem_write = 1'b1;
            end
            FN_STY: begin
                zn_en         = 1'b0;
                mem.mem_data  = cur.y;
                mem.mem_write = 1'b1;
            end
            default: begin
                zn_en = 1'b0;
            end
        endcase
        if (zn_en) begin
            nxt.flags[FL_Z] = zn_val == 8'd0;
            nxt.flags[FL_N] = zn_val[7];
        end
        nxt.flags[FL_U] = 1'b1;
    end

endmodule

// File: rtl/core/alu_8bit_bcd_execute.sv
`timescale 1ns / 1ps

// Execute unit of an 8-bit processor with decimal-mode add and subtract.
// The input channel (s_valid, s_ready) carries one decoded operation, its
// operand byte and the accumulator-target bit. The result channel (m_valid,
// m_ready) returns the accumulator, X, Y, stack pointer and status byte after
// the operation, plus a memory write byte and its strobe.
// An accepted item is held in an input register, where the operation is
// evaluated against the architectural registers; these are updated at the
// same edge that loads the result register, which drives m_valid. One item
// is taken every cycle as long as the receiver keeps m_ready high.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; s_ready drops only when both are full.
// Reset clears both registers' valid bits, sets A, X and Y to zero, the
// stack pointer to 0xFD and the status byte to 0x20.

module alu_8bit_bcd_execute (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [5:0] s_func,
    input  logic [7:0] s_operand,
    input  logic       s_on_accumulator,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_x_out,
    output logic [7:0] m_y_out,
    output logic [7:0] m_sp_out,
    output logic [7:0] m_flags_out,
    output logic [7:0] m_mem_data,
    output logic       m_mem_write
);

    import abe_pkg::*;

    logic       in_valid_reg;
    logic [5:0] func_reg;
    logic [7:0] operand_reg;
    logic       on_acc_reg;
    logic       out_valid_reg;
    arch_t      arch_reg;
    arch_t      arch_next;
    mem_req_t   mem_next;
    arch_t      res_arch_reg;
    mem_req_t   res_mem_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    abe_exec u_exec (
        .func           (func_reg),
        .operand        (operand_reg),
        .on_accumulator (on_acc_reg),
        .cur            (arch_reg),
        .nxt            (arch_next),
        .mem            (mem_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            arch_reg.acc   <= 8'd0;
            arch_reg.x     <= 8'd0;
            arch_reg.y     <= 8'd0;
            arch_reg.sp    <= SP_RESET;
            arch_reg.flags <= FLAGS_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                arch_reg      <= arch_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            func_reg    <= s_func;
            operand_reg <= s_operand;
            on_acc_reg  <= s_on_accumulator;
        end
        if (advance) begin
            res_arch_reg <= arch_next;
            res_mem_reg  <= mem_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_acc_out   = res_arch_reg.acc;
    assign m_x_out     = res_arch_reg.x;
    assign m_y_out     = res_arch_reg.y;
    assign m_sp_out    = res_arch_reg.sp;
    assign m_flags_out = res_arch_reg.flags;
    assign m_mem_data  = res_mem_reg.mem_data;
    assign m_mem_write = res_mem_reg.mem_write;

endmodule

// File: verif/tb_alu_8bit_bcd_execute.sv
`timescale 1ns / 1ps

module tb_alu_8bit_bcd_execute;
    import abe_pkg::*;

    localparam int FUNC_MAX = 63;

    typedef struct packed {
        logic [5:0] func;
        logic [7:0] operand;
        logic       on_acc;
    } op_item_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
        logic [7:0] mem_data;
        logic       mem_write;
    } exec_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [5:0] s_func = '0;
    logic [7:0] s_operand = '0;
    logic       s_on_accumulator = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_acc_out;
    logic [7:0] m_x_out;
    logic [7:0] m_y_out;
    logic [7:0] m_sp_out;
    logic [7:0] m_flags_out;
    logic [7:0] m_mem_data;
    logic       m_mem_write;

    logic [7:0] arch_acc = '0;
    logic [7:0] arch_x = '0;
    logic [7:0] arch_y = '0;
    logic [7:0] arch_sp = SP_RESET;
    logic [7:0] arch_flags = FLAGS_RESET;

    op_item_t  pending_ops[$];
    exec_out_t expected_results[$];
    int        ops_queued = 0;
    int        ops_taken = 0;
    int        mismatches = 0;
    int        send_idle = 22;
    int        recv_idle = 78;
    logic      in_taken = 1'b0;

    alu_8bit_bcd_execute u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_operand        (s_operand),
        .s_on_accumulator (s_on_accumulator),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_acc_out        (m_acc_out),
        .m_x_out          (m_x_out),
        .m_y_out          (m_y_out),
        .m_sp_out         (m_sp_out),
        .m_flags_out      (m_flags_out),
        .m_mem_data       (m_mem_data),
        .m_mem_write      (m_mem_write)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic exec_out_t execute_op(input op_item_t op);
        exec_out_t  r;
        logic [7:0] a, x, y, sp, fl, m, src, t, wdata, zn_val;
        logic       cin, wr, upd_zn;
        int         ai, mi, sum, dec, brw;
        a = arch_acc;
        x = arch_x;
        y = arch_y;
        sp = arch_sp;
        fl = arch_flags;
        m = op.operand;
        cin = fl[FL_C];
        wdata = '0;
        wr = 1'b0;
        upd_zn = 1'b0;
        zn_val = '0;
        src = op.on_acc ? a : m;
        t = '0;
        ai = a;
        mi = m;
        case (op.func)
            FN_ADC: begin
                sum = ai + mi + int'(cin);
                fl[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
                if (fl[FL_D]) begin
                    dec = sum;
                    if (int'(a[3:0]) + int'(m[3:0]) + int'(cin) > 9) dec = dec + 6;
                    if (dec > 'h99) dec = dec + 'h60;
                    fl[FL_C] = (dec > 'h99);
                    a = dec[7:0];
                end else begin
                    fl[FL_C] = (sum > 'hFF);
                    a = sum[7:0];
                end
                upd_zn = 1'b1;
                zn_val = a;
            end
            FN_SBC: begin
                sum = ai + (255 - mi) + int'(cin);
                fl[FL_V] = (sum[7] ^ a[7]) & (sum[7] ^ ~m[7]);
                fl[FL_C] = (sum > 'hFF);
                if (fl[FL_D]) begin
                    brw = 1 - int'(cin);
                    dec = ai - mi - brw;
                    if (int'(a[3:0]) - brw < int'(m[3:0])) dec = dec - 6;
                    if (dec < 0) dec = dec - 96;
                    a = dec[7:0];
                end else begin
                    a = sum[7:0];
                end
                upd_zn = 1'b1;
                zn_val = a;
            end
            FN_AND: begin a = a & m; upd_zn = 1'b1; zn_val = a; end
            FN_ORA: begin a = a | m; upd_zn = 1'b1; zn_val = a; end
            FN_EOR: begin a = a ^ m; upd_zn = 1'b1; zn_val = a; end
            FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
                case (op.func)
                    FN_ASL: begin t = {src[6:0], 1'b0}; fl[FL_C] = src[7]; end
                    FN_LSR: begin t = {1'b0, src[7:1]}; fl[FL_C] = src[0]; end
                    FN_ROL: begin t = {src[6:0], cin}; fl[FL_C] = src[7]; end
                    default: begin t = {cin, src[7:1]}; fl[FL_C] = src[0]; end
                endcase
                upd_zn = 1'b1;
                zn_val = t;
                if (op.on_acc) begin
                    a = t;
                end else begin
                    wdata = t;
                    wr = 1'b1;
                end
            end
            FN_CMP: begin fl[FL_C] = (a >= m); upd_zn = 1'b1; zn_val = a - m; end
            FN_CPX: begin fl[FL_C] = (x >= m); upd_zn = 1'b1; zn_val = x - m; end
            FN_CPY: begin fl[FL_C] = (y >= m); upd_zn = 1'b1; zn_val = y - m; end
            FN_INC: begin wdata = m + 8'd1; wr = 1'b1; upd_zn = 1'b1; zn_val = wdata; end
            FN_DEC: begin wdata = m - 8'd1; wr = 1'b1; upd_zn = 1'b1; zn_val = wdata; end
            FN_BIT: begin
                fl[FL_Z] = ((a & m) == 8'h00);
                fl[FL_N] = m[7];
                fl[FL_V] = m[6];
            end
            FN_LDA: begin a = m; upd_zn = 1'b1; zn_val = a; end
            FN_LDX: begin x = m; upd_zn = 1'b1; zn_val = x; end
            FN_LDY: begin y = m; upd_zn = 1'b1; zn_val = y; end
            FN_INX: begin x = x + 8'd1; upd_zn = 1'b1; zn_val = x; end
            FN_INY: begin y = y + 8'd1; upd_zn = 1'b1; zn_val = y; end
            FN_DEX: begin x = x - 8'd1; upd_zn = 1'b1; zn_val = x; end
            FN_DEY: begin y = y - 8'd1; upd_zn = 1'b1; zn_val = y; end
            FN_TAX: begin x = a; upd_zn = 1'b1; zn_val = x; end
            FN_TAY: begin y = a; upd_zn = 1'b1; zn_val = y; end
            FN_TXA: begin a = x; upd_zn = 1'b1; zn_val = a; end
            FN_TYA: begin a = y; upd_zn = 1'b1; zn_val = a; end
            FN_TSX: begin x = sp; upd_zn = 1'b1; zn_val = x; end
            FN_TXS: sp = x;
            FN_CLC: fl[FL_C] = 1'b0;
            FN_SEC: fl[FL_C] = 1'b1;
            FN_CLD: fl[FL_D] = 1'b0;
            FN_SED: fl[FL_D] = 1'b1;
            FN_CLI: fl[FL_I] = 1'b0;
            FN_SEI: fl[FL_I] = 1'b1;
            FN_CLV: fl[FL_V] = 1'b0;
            FN_STA: begin wdata = a; wr = 1'b1; end
            FN_STX: begin wdata = x; wr = 1'b1; end
            FN_STY: begin wdata = y; wr = 1'b1; end
            default: ;
        endcase
        if (upd_zn) begin
            fl[FL_Z] = (zn_val == 8'h00);
            fl[FL_N] = zn_val[7];
        end
        fl[FL_U] = 1'b1;
        arch_acc = a;
        arch_x = x;
        arch_y = y;
        arch_sp = sp;
        arch_flags = fl;
        r.acc = a;
        r.x = x;
        r.y = y;
        r.sp = sp;
        r.flags = fl;
        r.mem_data = wr ? wdata : 8'h00;
        r.mem_write = wr;
        return r;
    endfunction

    function automatic op_item_t random_op();
        op_item_t op;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 14) op.func = FN_ADC;
        else if (pick < 28) op.func = FN_SBC;
        else if (pick < 36) op.func = 6'($urandom_range(FN_CLC, FN_SED));
        else if (pick < 40) op.func = 6'($urandom_range(int'(FN_STY) + 1, FUNC_MAX));
        else op.func = 6'($urandom_range(0, FN_STY));
        if ($urandom_range(1)) op.operand = {4'($urandom_range(9)), 4'($urandom_range(9))};
        else op.operand = 8'($urandom);
        op.on_acc = 1'($urandom);
        return op;
    endfunction

    task automatic push_op(input logic [5:0] func, input logic [7:0] operand,
                           input logic on_acc);
        pending_ops.push_back('{func: func, operand: operand, on_acc: on_acc});
        ops_queued++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        op_item_t nxt;
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt = pending_ops.pop_front();
                s_func <= nxt.func;
                s_operand <= nxt.operand;
                s_on_accumulator <= nxt.on_acc;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        exec_out_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no expected item");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("acc_out", want.acc, m_acc_out);
                    check_field("x_out", want.x, m_x_out);
                    check_field("y_out", want.y, m_y_out);
                    check_field("sp_out", want.sp, m_sp_out);
                    check_field("flags_out", want.flags, m_flags_out);
                    check_field("mem_data", want.mem_data, m_mem_data);
                    check_field("mem_write", {7'd0, want.mem_write}, {7'd0, m_mem_write});
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(execute_op('{func: s_func, operand: s_operand,
                                                        on_acc: s_on_accumulator}));
                ops_taken++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Every operation once, with operand and target extremes.
        for (int f = 0; f <= FN_STY; f++) begin
            push_op(6'(f), (f % 2 == 1) ? 8'hFF : 8'h00, f[1]);
        end
        // Decimal carry and borrow at the edges of the BCD range, then an undefined code and a binary overflow.
        push_op(FN_SED, 8'h00, 1'b0);
        push_op(FN_CLC, 8'h00, 1'b0);
        push_op(FN_LDA, 8'h99, 1'b0);
        push_op(FN_ADC, 8'h01, 1'b0);
        push_op(FN_ADC, 8'h99, 1'b0);
        push_op(FN_SEC, 8'h00, 1'b0);
        push_op(FN_SBC, 8'h99, 1'b0);
        push_op(FN_CLC, 8'h00, 1'b0);
        push_op(FN_SBC, 8'h00, 1'b0);
        push_op(FN_LDA, 8'h58, 1'b0);
        push_op(FN_ADC, 8'h46, 1'b0);
        push_op(6'(FUNC_MAX), 8'hFF, 1'b1);
        push_op(FN_CLD, 8'h00, 1'b0);
        push_op(FN_LDA, 8'h7F, 1'b0);
        push_op(FN_ADC, 8'h01, 1'b0);
        repeat (600) pending_ops.push_back(random_op());
        ops_queued += 600;
        while (ops_taken != ops_queued) @(posedge aclk);

        send_idle = 78;
        recv_idle = 22;
        repeat (650) pending_ops.push_back(random_op());
        ops_queued += 650;
        while (ops_taken != ops_queued) @(posedge aclk);

        send_idle = 0;
        recv_idle = 0;
        repeat (650) pending_ops.push_back(random_op());
        ops_queued += 650;
        while (ops_taken != ops_queued) @(posedge aclk);

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
